[rtl/core/pft_pkg.sv]
// shared types and constants for the protobuf field tokenizer
`timescale 1ns / 1ps

package pft_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int TDATA_W = 112;

	// decode phase of the tokenizer
	typedef enum logic [2:0] {
		PH_KEY     = 3'd0,
		PH_VALUE   = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_FIXED   = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_VARINT  = 3'd0,
		EV_FIXED64 = 3'd1,
		EV_HEADER  = 3'd2,
		EV_PAYLOAD = 3'd3,
		EV_FIXED32 = 3'd4,
		EV_ERROR   = 3'd5
	} event_kind_t;

	typedef enum logic [1:0] {
		ERR_WIRE_TYPE   = 2'd0,
		ERR_TRUNC_VAR   = 2'd1,
		ERR_OVERLONG    = 2'd2,
		ERR_TRUNC_FIELD = 2'd3
	} error_code_t;

	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LEN     = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	typedef struct packed {
		event_kind_t kind;
		logic [31:0] field_number;
		logic [63:0] field_value;
		logic [7:0]  payload_byte;
		logic        last_of_field;
		error_code_t error_code;
	} event_t;

endpackage

[rtl/core/protobuf_field_tokenizer_unit.sv]
// Protobuf wire-format field tokenizer, stream in one byte per transaction.
// Throughput: one byte per cycle while s_tready is high, one event per byte at most.
// The decode stage writes each event into the event queue, from which it moves into
// the output register that drives m_tdata.
// s_tready drops only when the event queue is full behind a stalled output.
// Reset (arst_n low, asynchronous): decoder awaits a key, queue and output empty.
`timescale 1ns / 1ps

module protobuf_field_tokenizer_unit #(
	parameter int QUEUE_DEPTH = pft_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] in_byte
	input  logic                         s_tlast,   // end_of_buffer
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] field_number, [95:32] field_value, [103:96] payload_byte,
	// [105:104] error_code, [111:106] zero
	output logic [pft_pkg::TDATA_W-1:0]  m_tdata,
	output logic [2:0]                   m_tuser,   // [2:0] event_kind
	output logic                         m_tlast    // last_of_field
);

	logic            fire;
	logic            ev_valid;
	pft_pkg::event_t ev;
	logic            q_full;
	logic            q_pop;
	logic            q_not_empty;
	pft_pkg::event_t q_head;

	assign s_tready = !q_full;
	assign fire     = s_tvalid && s_tready;

	pft_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.in_byte       (s_tdata),
		.end_of_buffer (s_tlast),
		.ev_valid      (ev_valid),
		.ev            (ev)
	);

	pft_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && ev_valid),
		.push_ev   (ev),
		.full      (q_full),
		.pop       (q_pop),
		.head_ev   (q_head),
		.not_empty (q_not_empty)
	);

	pft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head_ev   (q_head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

[rtl/core/pft_front.sv]
// front end: per-byte wire-format decode into field events
`timescale 1ns / 1ps

module pft_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      in_byte,
	input  logic            end_of_buffer,
	output logic            ev_valid,
	output pft_pkg::event_t ev
);

	pft_pkg::phase_t phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [31:0] field_q, field_d;
	logic [2:0]  wire_q, wire_d;
	logic [63:0] rem_q, rem_d;
	logic        hold_q;

	logic [6:0]  vsh;
	logic [63:0] vacc;
	logic        v_overlong, v_more;
	logic [2:0]  fidx;
	logic [63:0] facc;
	logic [63:0] rem_dec;
	logic        rem_zero;
	logic [2:0]  key_wire;
	logic [31:0] key_field;
	logic        v_zero;

	// varint merge: bits above 63 of a tenth byte fall off
	assign vsh        = {3'b000, cnt_q} * 7'd7;
	assign vacc       = acc_q | ({57'd0, in_byte[6:0]} << vsh);
	assign v_overlong = (cnt_q > 4'd9) || (in_byte[7] && cnt_q == 4'd9);
	assign v_more     = in_byte[7] && cnt_q < 4'd9;
	assign v_zero     = vacc == 64'd0;
	assign key_wire   = vacc[2:0];
	assign key_field  = vacc[34:3];

	// little-endian fixed assembly
	assign fidx     = cnt_q[2:0];
	assign facc     = acc_q | ({56'd0, in_byte} << {fidx, 3'b000});
	assign rem_dec  = rem_q - 64'd1;
	assign rem_zero = rem_dec == 64'd0;

	// event produced by the current byte
	always_comb begin
		ev_valid         = 1'b0;
		ev.kind          = pft_pkg::EV_ERROR;
		ev.field_number  = 32'd0;
		ev.field_value   = 64'd0;
		ev.payload_byte  = 8'd0;
		ev.last_of_field = 1'b0;
		ev.error_code    = pft_pkg::ERR_WIRE_TYPE;
		if (!hold_q) begin
			unique case (phase_q)
				pft_pkg::PH_FIXED: begin
					if (rem_zero) begin
						ev_valid        = 1'b1;
						ev.kind         = (wire_q == pft_pkg::WIRE_FIXED64) ?
							pft_pkg::EV_FIXED64 : pft_pkg::EV_FIXED32;
						ev.field_number = field_q;
						ev.field_value  = facc;
					end else if (end_of_buffer) begin
						ev_valid      = 1'b1;
						ev.error_code = pft_pkg::ERR_TRUNC_FIELD;
					end
				end
				pft_pkg::PH_PAYLOAD: begin
					if (!rem_zero && end_of_buffer) begin
						ev_valid      = 1'b1;
						ev.error_code = pft_pkg::ERR_TRUNC_FIELD;
					end else begin
						ev_valid         = 1'b1;
						ev.kind          = pft_pkg::EV_PAYLOAD;
						ev.field_number  = field_q;
						ev.payload_byte  = in_byte;
						ev.last_of_field = rem_zero;
					end
				end
				default: begin
					if (v_overlong) begin
						ev_valid      = 1'b1;
						ev.error_code = pft_pkg::ERR_OVERLONG;
					end else if (v_more) begin
						if (end_of_buffer) begin
							ev_valid      = 1'b1;
							ev.error_code = pft_pkg::ERR_TRUNC_VAR;
						end
					end else if (phase_q == pft_pkg::PH_VALUE) begin
						ev_valid        = 1'b1;
						ev.kind         = pft_pkg::EV_VARINT;
						ev.field_number = field_q;
						ev.field_value  = vacc;
					end else if (phase_q == pft_pkg::PH_LENGTH) begin
						if (!v_zero && end_of_buffer) begin
							ev_valid      = 1'b1;
							ev.error_code = pft_pkg::ERR_TRUNC_FIELD;
						end else begin
							ev_valid         = 1'b1;
							ev.kind          = pft_pkg::EV_HEADER;
							ev.field_number  = field_q;
							ev.field_value   = vacc;
							ev.last_of_field = v_zero;
						end
					end else begin
						unique case (key_wire) inside
							pft_pkg::WIRE_VARINT, pft_pkg::WIRE_LEN: begin
								if (end_of_buffer) begin
									ev_valid      = 1'b1;
									ev.error_code = pft_pkg::ERR_TRUNC_VAR;
								end
							end
							pft_pkg::WIRE_FIXED64, pft_pkg::WIRE_FIXED32: begin
								if (end_of_buffer) begin
									ev_valid      = 1'b1;
									ev.error_code = pft_pkg::ERR_TRUNC_FIELD;
								end
							end
							default: begin
								ev_valid      = 1'b1;
								ev.error_code = pft_pkg::ERR_WIRE_TYPE;
							end
						endcase
					end
				end
			endcase
		end
	end

	// next decode state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		field_d = field_q;
		wire_d  = wire_q;
		rem_d   = rem_q;
		unique case (phase_q)
			pft_pkg::PH_FIXED: begin
				rem_d = rem_dec;
				if (rem_zero) begin
					acc_d   = 64'd0;
					cnt_d   = 4'd0;
					phase_d = pft_pkg::PH_KEY;
				end else begin
					acc_d = facc;
					cnt_d = {1'b0, fidx} + 4'd1;
				end
			end
			pft_pkg::PH_PAYLOAD: begin
				rem_d = rem_dec;
				if (rem_zero)
					phase_d = pft_pkg::PH_KEY;
			end
			default: begin
				if (v_overlong) begin
					acc_d = acc_q;
				end else if (v_more) begin
					acc_d = vacc;
					cnt_d = cnt_q + 4'd1;
				end else begin
					acc_d = 64'd0;
					cnt_d = 4'd0;
					if (phase_q == pft_pkg::PH_VALUE) begin
						phase_d = pft_pkg::PH_KEY;
					end else if (phase_q == pft_pkg::PH_LENGTH) begin
						if (v_zero) begin
							phase_d = pft_pkg::PH_KEY;
						end else begin
							rem_d   = vacc;
							phase_d = pft_pkg::PH_PAYLOAD;
						end
					end else begin
						field_d = key_field;
						wire_d  = key_wire;
						unique case (key_wire) inside
							pft_pkg::WIRE_VARINT:  phase_d = pft_pkg::PH_VALUE;
							pft_pkg::WIRE_LEN:     phase_d = pft_pkg::PH_LENGTH;
							pft_pkg::WIRE_FIXED64: begin
								phase_d = pft_pkg::PH_FIXED;
								rem_d   = 64'd8;
							end
							pft_pkg::WIRE_FIXED32: begin
								phase_d = pft_pkg::PH_FIXED;
								rem_d   = 64'd4;
							end
							default: phase_d = phase_q;
						endcase
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pft_pkg::PH_KEY;
			acc_q   <= 64'd0;
			cnt_q   <= 4'd0;
			field_q <= 32'd0;
			wire_q  <= 3'd0;
			rem_q   <= 64'd0;
			hold_q  <= 1'b0;
		end else if (fire) begin
			if (end_of_buffer) begin
				// buffer done: start the next message clean
				phase_q <= pft_pkg::PH_KEY;
				acc_q   <= 64'd0;
				cnt_q   <= 4'd0;
				field_q <= 32'd0;
				wire_q  <= 3'd0;
				rem_q   <= 64'd0;
				hold_q  <= 1'b0;
			end else if (!hold_q) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
				field_q <= field_d;
				wire_q  <= wire_d;
				rem_q   <= rem_d;
				hold_q  <= ev_valid && ev.kind == pft_pkg::EV_ERROR;
			end
		end
	end

`ifndef SYNTHESIS
	a_err_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ev_valid && ev.kind == pft_pkg::EV_ERROR && !end_of_buffer |=> hold_q)
		else $error("error event did not set the drop state");
	a_hold_silent: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> !ev_valid)
		else $error("event produced while dropping bytes");
	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_buffer |=> phase_q == pft_pkg::PH_KEY && !hold_q && cnt_q == 4'd0)
		else $error("decoder not back at key after end of buffer");
`endif

endmodule

[rtl/core/pft_queue.sv]
// short event queue between the decode front and the output stage
`timescale 1ns / 1ps

module pft_queue #(
	parameter int DEPTH = pft_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pft_pkg::event_t push_ev,
	output logic            full,
	input  logic            pop,
	output pft_pkg::event_t head_ev,
	output logic            not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	pft_pkg::event_t slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head_ev   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

[rtl/core/pft_back.sv]
// back end: output register and stream packing of events
`timescale 1ns / 1ps

module pft_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         not_empty,
	input  pft_pkg::event_t              head_ev,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pft_pkg::TDATA_W-1:0]  m_tdata,
	output logic [2:0]                   m_tuser,
	output logic                         m_tlast
);

	pft_pkg::event_t out_q;
	logic            valid_q;
	logic            load;

	// output register refills whenever it is empty or being drained
	assign load = !valid_q || m_tready;
	assign pop  = not_empty && load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= head_ev;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, out_q.error_code, out_q.payload_byte,
		out_q.field_value, out_q.field_number};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last_of_field;

endmodule
